@@ rtl/fbtu_pkg.sv @@
// ----------------------------------------------------------------------------
// fbtu_pkg
// Shared constants and the code-to-character map of the five-bit text
// unpacker.
// ----------------------------------------------------------------------------
package fbtu_pkg;

    localparam int unsigned CODE_BITS  = 5;
    localparam int unsigned BYTE_BITS  = 8;
    localparam int unsigned LEFT_BITS  = 4;
    localparam int unsigned LEFT_CNT_W = 3;
    localparam int unsigned ACC_BITS   = LEFT_BITS + BYTE_BITS;
    localparam int unsigned TOTAL_W    = 4;

    typedef logic [CODE_BITS-1:0] code_t;
    typedef logic [BYTE_BITS-1:0] char_t;

    localparam code_t ESCAPE_CODE  = 5'd31;
    localparam code_t LAST_LETTER  = 5'd25;
    localparam code_t CODE_SPACE   = 5'd26;
    localparam code_t CODE_NEWLINE = 5'd27;
    localparam code_t CODE_PERIOD  = 5'd28;
    localparam code_t CODE_COMMA   = 5'd29;

    localparam char_t CHAR_A       = 8'h61;
    localparam char_t CHAR_SPACE   = 8'h20;
    localparam char_t CHAR_NEWLINE = 8'h0A;
    localparam char_t CHAR_PERIOD  = 8'h2E;
    localparam char_t CHAR_COMMA   = 8'h2C;
    localparam char_t CHAR_QUEST   = 8'h3F;
    localparam char_t SHIFT_DELTA  = 8'h20;

    function automatic char_t map_code(input code_t code);
        char_t ch;
        if (code <= LAST_LETTER) begin
            ch = CHAR_A + char_t'(code);
        end else if (code == CODE_SPACE) begin
            ch = CHAR_SPACE;
        end else if (code == CODE_NEWLINE) begin
            ch = CHAR_NEWLINE;
        end else if (code == CODE_PERIOD) begin
            ch = CHAR_PERIOD;
        end else if (code == CODE_COMMA) begin
            ch = CHAR_COMMA;
        end else begin
            ch = CHAR_QUEST;
        end
        return ch;
    endfunction

endpackage

@@ rtl/five_bit_text_unpacker.sv @@
// Five-bit text unpacker. Each accepted byte is split most significant bit
// first into 5-bit codes, with up to four leftover bits carried into the next
// byte, and each completed code but code 31 becomes one character; code 31
// shifts the following code to its uppercase form. A byte yields zero, one or
// two characters, and m_last marks the final one of its byte. The single
// result channel drains the two-entry result register, so a byte that yields
// two characters holds off the next byte until only its second one remains.
// A byte passes through the input register and the result register before its
// first character reaches the port. Leftover bits at the end of a stream are
// dropped.
// ----------------------------------------------------------------------------
// five_bit_text_unpacker
// Unpacks 5-bit codes from a byte stream into character bytes.
// ----------------------------------------------------------------------------
module five_bit_text_unpacker (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  fbtu_pkg::char_t      s_data_byte,
    output logic                 m_valid,
    input  logic                 m_ready,
    output fbtu_pkg::char_t      m_character,
    output logic                 m_last
);
    import fbtu_pkg::*;

    // Input register.
    logic                  in_valid_reg;
    char_t                 in_data_reg;

    // Decode state.
    logic [LEFT_BITS-1:0]  left_bits_reg,  left_bits_next;
    logic [LEFT_CNT_W-1:0] left_cnt_reg,   left_cnt_next;
    logic                  shift_reg,      shift_next;

    // Result register: res0 is always the character on the port.
    char_t                 res0_reg, res0_next;
    char_t                 res1_reg, res1_next;
    logic [1:0]            res_cnt_reg, res_cnt_next;

    logic                  res_free;
    logic                  move;

    logic [ACC_BITS-1:0]   acc;
    logic [TOTAL_W-1:0]    total;
    logic [TOTAL_W-1:0]    remain;
    logic [TOTAL_W-1:0]    sh1;
    logic [TOTAL_W-1:0]    sh2;
    logic                  two_codes;
    code_t                 code1, code2;
    logic                  emit1, emit2;
    logic                  shift_mid;
    char_t                 ch1, ch2;
    logic [LEFT_BITS-1:0]  left_mask;

    assign res_free = (res_cnt_reg == 2'd0) || ((res_cnt_reg == 2'd1) && m_ready);
    assign move     = in_valid_reg && res_free;
    assign s_ready  = !in_valid_reg || move;

    assign m_valid     = (res_cnt_reg != 2'd0);
    assign m_last      = (res_cnt_reg == 2'd1);
    assign m_character = res0_reg;

    always_comb begin
        acc       = {left_bits_reg, in_data_reg};
        total     = TOTAL_W'(left_cnt_reg) + TOTAL_W'(BYTE_BITS);
        two_codes = (total >= TOTAL_W'(2 * CODE_BITS));
        sh1       = total - TOTAL_W'(CODE_BITS);
        sh2       = two_codes ? (total - TOTAL_W'(2 * CODE_BITS)) : '0;
        code1     = code_t'(acc >> sh1);
        code2     = code_t'(acc >> sh2);
        remain    = two_codes ? sh2 : sh1;

        // A code emits unless it is the escape; an escaped escape cancels the shift.
        emit1     = (code1 != ESCAPE_CODE);
        ch1       = map_code(code1) - (shift_reg ? SHIFT_DELTA : '0);
        shift_mid = (code1 == ESCAPE_CODE) && !shift_reg;

        emit2     = two_codes && (code2 != ESCAPE_CODE);
        ch2       = map_code(code2) - (shift_mid ? SHIFT_DELTA : '0);
        shift_next = two_codes ? ((code2 == ESCAPE_CODE) && !shift_mid) : shift_mid;

        left_mask      = LEFT_BITS'((5'd1 << remain) - 5'd1);
        left_bits_next = acc[LEFT_BITS-1:0] & left_mask;
        left_cnt_next  = remain[LEFT_CNT_W-1:0];
    end

    always_comb begin
        res0_next    = res0_reg;
        res1_next    = res1_reg;
        res_cnt_next = res_cnt_reg;
        if (move) begin
            res_cnt_next = 2'(emit1) + 2'(emit2);
            res0_next    = emit1 ? ch1 : ch2;
            res1_next    = ch2;
        end else if (m_valid && m_ready) begin
            res_cnt_next = res_cnt_reg - 2'd1;
            res0_next    = res1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            left_bits_reg <= '0;
            left_cnt_reg  <= '0;
            shift_reg     <= 1'b0;
            res_cnt_reg   <= 2'd0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (move) begin
                in_valid_reg <= 1'b0;
            end
            if (move) begin
                left_bits_reg <= left_bits_next;
                left_cnt_reg  <= left_cnt_next;
                shift_reg     <= shift_next;
            end
            res_cnt_reg <= res_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data_byte;
        end
        res0_reg <= res0_next;
        res1_reg <= res1_next;
    end

endmodule

@@ rtl/fbtu_checker.sv @@
// ----------------------------------------------------------------------------
// fbtu_checker
// Port-level checks of the five-bit text unpacker.
// ----------------------------------------------------------------------------
module fbtu_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_valid,
    input logic                 m_ready,
    input fbtu_pkg::char_t      m_character,
    input logic                 m_last
);
    import fbtu_pkg::*;

    // A stalled result holds its character and flag.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_character) && $stable(m_last))
        else $error("stalled result changed");

    // Both characters of a byte sit in the result register, so the second
    // one follows the first without a gap.
    a_pair_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last |=> m_valid)
        else $error("second character of a byte did not follow");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result pending after reset");

endmodule

bind five_bit_text_unpacker fbtu_checker u_fbtu_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_character (m_character),
    .m_last      (m_last)
);
